>>> rtl/nqfs_pkg.sv
// Shared types and constants for the N-queens first-solution search.
`timescale 1ns / 1ps

package nqfs_pkg;

    localparam int SIZE_W = 5;  // board size request field
    localparam int POS_W  = 5;  // row / column counters, can hold the size itself
    localparam int ROW_W  = 4;  // row index on the result channel
    localparam int COL_W  = 4;  // stored queen column
    localparam int SIZE_CAP = 16;  // most results one request can produce

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRY,
        ST_POP,
        ST_CHECK,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_FAIL
    } t_phase;

endpackage

>>> rtl/nqfs_conflict.sv
// Attack test of a candidate square against one queen of an earlier row.
`timescale 1ns / 1ps

module nqfs_conflict (
    input  logic [nqfs_pkg::POS_W-1:0] i_row,
    input  logic [nqfs_pkg::POS_W-1:0] i_chk,
    input  logic [nqfs_pkg::POS_W-1:0] i_col,
    input  logic [nqfs_pkg::COL_W-1:0] i_other,
    output logic                       o_hit
);
    import nqfs_pkg::*;

    logic [POS_W-1:0] row_gap;
    logic [POS_W:0]   other_w;
    logic [POS_W:0]   col_w;
    logic [POS_W:0]   other_up;
    logic [POS_W:0]   col_up;

    always_comb begin
        row_gap  = i_row - i_chk;
        other_w  = (POS_W+1)'(i_other);
        col_w    = {1'b0, i_col};
        other_up = other_w + {1'b0, row_gap};
        col_up   = col_w + {1'b0, row_gap};
        // same column, or either upper diagonal
        o_hit    = (other_w == col_w) || (other_up == col_w) || (col_up == other_w);
    end

endmodule

>>> rtl/n_queens_first_solution.sv
// Top level of the N-queens first-solution search engine.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one request: a board size
//   on i_board_size. Output channel (o_out_valid / i_out_ready) returns the
//   first placement found by a depth-first search, one result per row in row
//   order (o_found=1, o_row_index, o_queen_column), o_last on the final row.
//   Sizes with no placement (0, 2, 3, above the limit) give a single result
//   with o_found=0 and o_last=1.
// Operation:
//   One request at a time. A placement trial checks the earlier rows in turn
//   in ST_CHECK, since the queen columns live in a single-port stack memory
//   read one entry per cycle; a backtrack step passes through ST_POP.
//   Total time is data dependent. Each result passes through ST_OUT_RD and
//   ST_OUT_LD, which waits while the output register is still full.
// Reset:
//   i_rst_n (synchronous, active low) returns the engine to idle and drops
//   o_out_valid. The stack memory is not cleared; entries are written first.
// Stall:
//   Results sit in one output register; while i_out_ready is low the engine
//   holds the next result and waits. A new request may be taken while the
//   final result of the previous one is still waiting.

module n_queens_first_solution #(
    parameter int MAX_BOARD = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nqfs_pkg::SIZE_W-1:0]   i_board_size,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [nqfs_pkg::ROW_W-1:0]    o_row_index,
    output logic [nqfs_pkg::COL_W-1:0]    o_queen_column,
    output logic                          o_last
);
    import nqfs_pkg::*;

    localparam int AW         = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam int SIZE_LIMIT = (MAX_BOARD < SIZE_CAP) ? MAX_BOARD : SIZE_CAP;
    localparam logic [SIZE_W-1:0] LIMIT_CODE = SIZE_W'(SIZE_LIMIT);

    // queen column per row
    logic [COL_W-1:0] mem [MAX_BOARD];

    t_phase r_state, n_state;

    logic [SIZE_W-1:0] r_size, n_size;
    logic [POS_W-1:0]  r_row,  n_row;   // row being placed
    logic [POS_W-1:0]  r_col,  n_col;   // candidate column of that row
    logic [POS_W-1:0]  r_chk,  n_chk;   // earlier row under test / result row
    logic [COL_W-1:0]  r_rdata;

    logic              r_o_valid, n_o_valid;
    logic              r_o_found, n_o_found;
    logic [ROW_W-1:0]  r_o_row,   n_o_row;
    logic [COL_W-1:0]  r_o_col,   n_o_col;
    logic              r_o_last,  n_o_last;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [COL_W-1:0]  wr_data;

    logic              out_free;
    logic              hit;
    logic              size_bad;
    logic [POS_W-1:0]  chk_nx;
    logic [POS_W-1:0]  row_dn;
    logic              load;

    nqfs_conflict u_conflict (
        .i_row   (r_row),
        .i_chk   (r_chk),
        .i_col   (r_col),
        .i_other (r_rdata),
        .o_hit   (hit)
    );

    assign out_free = !r_o_valid || i_out_ready;
    assign size_bad = (i_board_size == '0) || (i_board_size > LIMIT_CODE);
    assign chk_nx   = r_chk + 1'b1;
    assign row_dn   = r_row - 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = size_bad ? ST_FAIL : ST_TRY;
                end
            end
            ST_TRY: begin
                if (r_row >= r_size) begin
                    n_state = ST_OUT_RD;
                end else if (r_col >= r_size) begin
                    n_state = (r_row == '0) ? ST_FAIL : ST_POP;
                end else if (r_row != '0) begin
                    n_state = ST_CHECK;
                end
            end
            ST_POP:    n_state = ST_TRY;
            ST_CHECK: begin
                if (hit || chk_nx == r_row) begin
                    n_state = ST_TRY;
                end
            end
            ST_OUT_RD: n_state = ST_OUT_LD;
            ST_OUT_LD: begin
                if (out_free && chk_nx == r_size) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_state = ST_OUT_RD;
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_size    = r_size;
        n_row     = r_row;
        n_col     = r_col;
        n_chk     = r_chk;
        n_o_found = r_o_found;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_last  = r_o_last;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = r_row[AW-1:0];
        wr_data   = r_col[COL_W-1:0];
        load      = 1'b0;
        o_in_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_size = i_board_size;
                    n_row  = '0;
                    n_col  = '0;
                end
            end
            ST_TRY: begin
                if (r_row >= r_size) begin
                    n_chk = '0;
                end else if (r_col >= r_size) begin
                    // column exhausted: back up one row, fetch its column
                    if (r_row != '0) begin
                        n_row   = row_dn;
                        rd_en   = 1'b1;
                        rd_addr = row_dn[AW-1:0];
                    end
                end else if (r_row == '0) begin
                    wr_en = 1'b1;
                    n_row = r_row + 1'b1;
                    n_col = '0;
                end else begin
                    n_chk   = '0;
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            ST_POP: begin
                n_col = POS_W'(r_rdata) + 1'b1;
            end
            ST_CHECK: begin
                if (hit) begin
                    n_col = r_col + 1'b1;
                end else if (chk_nx == r_row) begin
                    // clear of every earlier queen: commit and descend
                    wr_en = 1'b1;
                    n_row = r_row + 1'b1;
                    n_col = '0;
                end else begin
                    n_chk   = chk_nx;
                    rd_en   = 1'b1;
                    rd_addr = chk_nx[AW-1:0];
                end
            end
            ST_OUT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_chk[AW-1:0];
            end
            ST_OUT_LD: begin
                if (out_free) begin
                    load      = 1'b1;
                    n_o_found = 1'b1;
                    n_o_row   = r_chk[ROW_W-1:0];
                    n_o_col   = r_rdata;
                    n_o_last  = (chk_nx == r_size);
                    n_chk     = chk_nx;
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    load      = 1'b1;
                    n_o_found = 1'b0;
                    n_o_row   = '0;
                    n_o_col   = '0;
                    n_o_last  = 1'b1;
                end
            end
            default: ;
        endcase
        n_o_valid = load || (r_o_valid && !i_out_ready);
    end

    // Reads and writes never hit the same entry in one cycle: writes go to
    // the current row, reads only to rows above it.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size    <= n_size;
        r_col     <= n_col;
        r_chk     <= n_chk;
        r_o_found <= n_o_found;
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
        r_o_last  <= n_o_last;
    end

    assign o_out_valid    = r_o_valid;
    assign o_found        = r_o_found;
    assign o_row_index    = r_o_row;
    assign o_queen_column = r_o_col;
    assign o_last         = r_o_last;

    // the row under test always lies above the row being placed
    a_chk_below_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_chk < r_row))
        else $error("check index not below current row");

    // the search never descends past the board
    a_row_in_board: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_row <= r_size))
        else $error("current row beyond board size");

    // a backtrack fetch only follows an exhausted column
    a_pop_from_try: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |-> ($past(r_state) == ST_TRY))
        else $error("backtrack fetch without exhausted row");

endmodule

>>> bench/tb_n_queens_first_solution.sv
// Self-checking testbench for the N-queens first-solution search engine.
`timescale 1ns / 1ps

module tb_n_queens_first_solution;
    import nqfs_pkg::*;

    localparam int MAX_BOARD   = 16;
    // Largest size that is actually searched; anything above gives not-found.
    localparam int BOARD_LIMIT = (MAX_BOARD < SIZE_CAP) ? MAX_BOARD : SIZE_CAP;
    localparam int RANDOM_REQS = 80;
    localparam int IDLE_PCT    = 22;
    localparam int QUIET_FROM  = 45;   // no idling on either side for these requests
    localparam int QUIET_TO    = 65;
    localparam int TAIL_CYCLES = 100;  // settle time after the last result
    // A 16x16 search runs long; only a handful are issued.
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } placement_t;

    typedef struct {
        logic [SIZE_W-1:0] size;
        bit                hold_for_drain;  // wait until all results are back
    } size_req_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [SIZE_W-1:0] i_board_size = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_found;
    logic [ROW_W-1:0]  o_row_index;
    logic [COL_W-1:0]  o_queen_column;
    logic              o_last;

    size_req_t  pending_sizes [$];
    placement_t placement_due [$];
    int         req_count  = 0;
    int         err_count  = 0;
    int         cycle_count = 0;
    logic       req_taken  = 1'b0;

    n_queens_first_solution #(
        .MAX_BOARD(MAX_BOARD)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_board_size   (i_board_size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_row_index    (o_row_index),
        .o_queen_column (o_queen_column),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Depth-first search, columns ascending per row; queues the rows of the
    // first placement, or a single not-found result.
    function automatic void predict_placement(input logic [SIZE_W-1:0] size);
        int unsigned n;
        int unsigned row;
        int unsigned r;
        int unsigned col_at [BOARD_LIMIT];
        bit          ok;
        bit          done;
        bit          clash;
        placement_t  p;
        n    = size;
        ok   = 1'b0;
        done = 1'b0;
        if (n != 0 && n <= BOARD_LIMIT) begin
            row       = 0;
            col_at[0] = 0;
            while (!done) begin
                if (row >= n) begin
                    ok   = 1'b1;
                    done = 1'b1;
                end else if (col_at[row] >= n) begin
                    // row exhausted: back up and advance the row above
                    if (row == 0) begin
                        done = 1'b1;
                    end else begin
                        row--;
                        col_at[row]++;
                    end
                end else begin
                    clash = 1'b0;
                    for (r = 0; r < row; r++) begin
                        if (col_at[r] == col_at[row] ||
                            col_at[r] + (row - r) == col_at[row] ||
                            col_at[row] + (row - r) == col_at[r])
                            clash = 1'b1;
                    end
                    if (!clash) begin
                        row++;
                        if (row < n)
                            col_at[row] = 0;
                    end else begin
                        col_at[row]++;
                    end
                end
            end
        end
        if (!ok) begin
            p = '{found: 1'b0, row: '0, col: '0, last: 1'b1};
            placement_due.push_back(p);
        end else begin
            for (r = 0; r < n; r++) begin
                p.found = 1'b1;
                p.row   = r[ROW_W-1:0];
                p.col   = col_at[r][COL_W-1:0];
                p.last  = (r + 1 == n);
                placement_due.push_back(p);
            end
        end
    endfunction

    function automatic void queue_request(input int size, input bit hold);
        size_req_t q;
        q.size           = size[SIZE_W-1:0];
        q.hold_for_drain = hold;
        pending_sizes.push_back(q);
    endfunction

    function automatic bit quiet_stretch();
        return (req_count >= QUIET_FROM && req_count < QUIET_TO);
    endfunction

    // Request driver: presents the next pending size, idling at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (pending_sizes.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_sizes[0].hold_for_drain && placement_due.size() != 0) begin
                i_in_valid <= 1'b0;
            end else if (!quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid   <= 1'b1;
                i_board_size <= pending_sizes[0].size;
                pending_sizes.pop_front();
            end
        end
    end

    // Result-side backpressure.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= quiet_stretch() || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predicts on each accepted request, then checks each result
    // against the oldest expected row.
    always @(posedge i_clk) begin
        placement_t exp_p;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_placement(i_board_size);
                req_count++;
                req_taken <= 1'b1;
            end else begin
                req_taken <= 1'b0;
            end
            if (o_out_valid && i_out_ready) begin
                if (placement_due.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected result: found=%0d row=%0d col=%0d last=%0d",
                                 o_found, o_row_index, o_queen_column, o_last);
                end else begin
                    exp_p = placement_due.pop_front();
                    if (o_found !== exp_p.found || o_row_index !== exp_p.row ||
                        o_queen_column !== exp_p.col || o_last !== exp_p.last) begin
                        err_count++;
                        if (err_count <= REPORT_MAX)
                            $display("mismatch exp f/r/c/l=%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     exp_p.found, exp_p.row, exp_p.col, exp_p.last,
                                     o_found, o_row_index, o_queen_column, o_last);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int k;
        int pick;
        int size;
        // Directed: smallest boards, the unsolvable sizes, zero, sizes past
        // the limit (top bit set) and every solvable size up to the largest.
        queue_request(1, 1'b0);
        queue_request(2, 1'b0);
        queue_request(3, 1'b0);
        queue_request(0, 1'b0);
        for (k = 4; k <= 8; k++)
            queue_request(k, 1'b0);
        queue_request(BOARD_LIMIT, 1'b0);
        queue_request(31, 1'b0);
        queue_request(BOARD_LIMIT + 1, 1'b0);
        queue_request(24, 1'b0);
        for (k = 9; k < BOARD_LIMIT; k++)
            queue_request(k, 1'b0);
        // Random: mostly small boards; large searches are kept rare.
        for (k = 0; k < RANDOM_REQS; k++) begin
            pick = $urandom_range(99);
            if (pick < 5)
                size = $urandom_range(31, BOARD_LIMIT + 1);
            else if (pick < 9)
                size = $urandom_range(BOARD_LIMIT, 13);
            else
                size = $urandom_range(12, 0);
            // one request is held back until the engine has fully drained
            queue_request(size, (k == RANDOM_REQS / 2));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_sizes.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (placement_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0 && placement_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
